@@ hdl/pid_drive_clamped_core_macros.svh @@
// Assertion macros shared by the checker of the clamped PID drive core.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef PID_DRIVE_CLAMPED_CORE_MACROS_SVH
`define PID_DRIVE_CLAMPED_CORE_MACROS_SVH

// Implication in the same cycle, off during reset.
`define PDC_CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, off during reset.
`define PDC_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked in the next cycle that also holds across reset.
`define PDC_CHK_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pdc_pkg.sv @@
// Package for the clamped PID drive core: widths, microcode format and program,
// and the shared clamp function. No dependencies.
`default_nettype none

package pdc_pkg;

    localparam int SP_W       = 16;
    localparam int TIME_W     = 32;
    localparam int GAIN_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int E_W        = 17;
    localparam int DE_W       = 18;
    localparam int DRV_W      = 17;
    localparam int MUL_A_W    = 33;
    localparam int MUL_B_W    = 18;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int MAG_W      = PROD_W - 1;
    localparam int DIV_NUM_W  = 56;
    localparam int DIV_DEN_W  = 37;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);
    localparam int SUM_W      = 58;
    localparam int PC_W       = 5;
    localparam int TIME_SCALE = 5;
    localparam int Q88_SHIFT  = 8;
    localparam int Q16_SHIFT  = 16;
    localparam int K125_W     = 7;
    localparam int STEP_MAG_W = 18;
    localparam int RECIP_W    = 24;
    localparam int STEP_SHIFT = 25;

    localparam logic [DRV_W-1:0]     ONE_Q16   = 17'h10000;
    localparam logic [K125_W-1:0]    D_SCALE   = 7'd125;

    // The integral step is |e|*m*32/125. At or above this magnitude it drives the
    // integral to a rail either way; below it the reciprocal multiply is exact.
    localparam logic [MAG_W-1:0]     STEP_SAT_MAG = 50'd256000;
    localparam logic [RECIP_W-1:0]   STEP_RECIP   = 24'd8589935;

    localparam logic [PC_W-1:0] PC_LOAD = 5'd0;
    localparam logic [PC_W-1:0] PC_HOLD = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP  = 2'd0,
        CFG_INTEG = 2'd1,
        CFG_DERIV = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_EM,
        OP_MUL_P,
        OP_MUL_I,
        OP_MUL_D,
        OP_ABS,
        OP_SCALE_I,
        OP_DIVLD_D,
        OP_DIV,
        OP_ACC,
        OP_ADD_P,
        OP_ADD_I,
        OP_ADD_D,
        OP_FINISH,
        OP_HOLD
    } t_op;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_WAIT_IN,
        C_WAIT_OUT,
        C_DIV,
        C_ZERO_DT
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            PC_W'(0):  w = '{op: OP_LOAD,    cond: C_WAIT_IN,  target: PC_W'(1)};
            PC_W'(1):  w = '{op: OP_NOP,     cond: C_ZERO_DT,  target: PC_HOLD};
            PC_W'(2):  w = '{op: OP_MUL_EM,  cond: C_NEXT,     target: PC_LOAD};
            PC_W'(3):  w = '{op: OP_ABS,     cond: C_NEXT,     target: PC_LOAD};
            PC_W'(4):  w = '{op: OP_SCALE_I, cond: C_NEXT,     target: PC_LOAD};
            PC_W'(5):  w = '{op: OP_ACC,     cond: C_NEXT,     target: PC_LOAD};
            PC_W'(6):  w = '{op: OP_MUL_P,   cond: C_NEXT,     target: PC_LOAD};
            PC_W'(7):  w = '{op: OP_ADD_P,   cond: C_NEXT,     target: PC_LOAD};
            PC_W'(8):  w = '{op: OP_MUL_I,   cond: C_NEXT,     target: PC_LOAD};
            PC_W'(9):  w = '{op: OP_ADD_I,   cond: C_NEXT,     target: PC_LOAD};
            PC_W'(10): w = '{op: OP_MUL_D,   cond: C_NEXT,     target: PC_LOAD};
            PC_W'(11): w = '{op: OP_ABS,     cond: C_NEXT,     target: PC_LOAD};
            PC_W'(12): w = '{op: OP_DIVLD_D, cond: C_NEXT,     target: PC_LOAD};
            PC_W'(13): w = '{op: OP_DIV,     cond: C_DIV,      target: PC_LOAD};
            PC_W'(14): w = '{op: OP_ADD_D,   cond: C_NEXT,     target: PC_LOAD};
            PC_W'(15): w = '{op: OP_FINISH,  cond: C_WAIT_OUT, target: PC_LOAD};
            PC_W'(16): w = '{op: OP_HOLD,    cond: C_WAIT_OUT, target: PC_LOAD};
            default:   w = '{op: OP_NOP,     cond: C_JUMP,     target: PC_LOAD};
        endcase
        return w;
    endfunction

    function automatic logic [DRV_W-1:0] clamp_unit(input logic signed [SUM_W-1:0] v);
        logic [DRV_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({{(SUM_W-DRV_W){1'b0}}, ONE_Q16})) begin
            r = ONE_Q16;
        end else begin
            r = v[DRV_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/pdc_if.sv @@
// Valid/ready channel interfaces of the clamped PID drive core.
// Depends on pdc_pkg for the field widths.
`default_nettype none

interface pdc_in_if import pdc_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [SP_W-1:0]   setpoint;
    logic signed [SP_W-1:0]   measured;
    logic [TIME_W-1:0]        now_ms;

    modport source (output valid, output setpoint, output measured, output now_ms,
                    input ready);
    modport sink   (input valid, input setpoint, input measured, input now_ms,
                    output ready);
endinterface

interface pdc_out_if import pdc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DRV_W-1:0]  drive;
    logic              held;

    modport source (output valid, output drive, output held, input ready);
    modport sink   (input valid, input drive, input held, output ready);
endinterface

`default_nettype wire

@@ hdl/pid_drive_clamped_core.sv @@
// Clamped PID drive controller: microcoded sequencer, shared multiplier, serial divider.
// Depends on pdc_pkg, pdc_if and pdc_divider.
//
//   channel    dir  handshake            payload
//   i_in_ch    in   valid/ready          setpoint, measured, now_ms
//   o_out_ch   out  valid/ready          drive, held
//   cfg        in   i_cfg_we             i_cfg_idx, i_cfg_data
//
// A word with nonzero elapsed time runs the full computation, most of it in the serial divider pass.
// A word with zero elapsed time goes straight to the hold step and repeats the last drive.
// A new word is taken only at the first microcode step; the output register lets it
// be taken while the previous result still waits.
// The last step waits while the output register is full and not taken.
// Reset is synchronous and clears gains, controller state and the output valid flag.
`default_nettype none

module pid_drive_clamped_core import pdc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pdc_in_if.sink                i_in_ch,
    pdc_out_if.source             o_out_ch
);

    logic [PC_W-1:0]          r_pc;
    logic [PC_W-1:0]          n_pc;
    logic signed [GAIN_W-1:0] r_kp;
    logic signed [GAIN_W-1:0] r_ki;
    logic signed [GAIN_W-1:0] r_kd;
    logic [DRV_W-1:0]         r_integ_acc;
    logic signed [E_W-1:0]    r_prev_error;
    logic [TIME_W-1:0]        r_prev_time;
    logic [DRV_W-1:0]         r_prev_drive;
    logic signed [E_W-1:0]    r_e;
    logic signed [DE_W-1:0]   r_de;
    logic [TIME_W-1:0]        r_m;
    logic [TIME_W-1:0]        r_now;
    logic signed [PROD_W-1:0] r_prod;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_neg;
    logic [DRV_W-1:0]         r_step;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_out_valid;
    logic [DRV_W-1:0]         r_drive;
    logic                     r_held;

    t_uword                   uw;
    logic                     in_fire;
    logic                     out_free;
    logic                     do_load;
    logic                     do_finish;
    logic                     do_hold;
    logic                     do_mul;
    t_div_ctl                 div_ctl;
    logic [DIV_NUM_W-1:0]     div_num;
    logic [DIV_DEN_W-1:0]     div_den;
    logic [DIV_NUM_W-1:0]     div_quot;
    logic                     div_last;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] neg_prod;
    logic [MAG_W+K125_W-1:0]  mag_x125;
    logic [STEP_MAG_W+RECIP_W-1:0] step_prod;
    logic [DRV_W-1:0]         step_q;
    logic signed [SUM_W-1:0]  step_ext;
    logic signed [SUM_W-1:0]  step_signed;
    logic signed [E_W-1:0]    in_err;
    logic signed [SUM_W-1:0]  q_ext;
    logic signed [SUM_W-1:0]  q_signed;
    logic signed [SUM_W-1:0]  acc_sum;
    logic signed [PROD_W-1:0] p_term;
    logic signed [PROD_W-1:0] i_term;
    logic [DRV_W-1:0]         drive_new;

    assign uw       = ucode(r_pc);
    assign in_fire  = i_in_ch.valid && i_in_ch.ready;
    assign out_free = !r_out_valid || o_out_ch.ready;

    assign i_in_ch.ready  = (r_pc == PC_LOAD);
    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.drive = r_drive;
    assign o_out_ch.held  = r_held;

    // Sequencer next step.
    always_comb begin
        case (uw.cond)
            C_NEXT:     n_pc = r_pc + PC_W'(1);
            C_JUMP:     n_pc = uw.target;
            C_WAIT_IN:  n_pc = in_fire ? uw.target : r_pc;
            C_WAIT_OUT: n_pc = out_free ? uw.target : r_pc;
            C_DIV:      n_pc = div_last ? r_pc + PC_W'(1) : r_pc;
            C_ZERO_DT:  n_pc = (r_m == '0) ? uw.target : r_pc + PC_W'(1);
            default:    n_pc = PC_LOAD;
        endcase
    end

    // Control word decode.
    always_comb begin
        do_load      = (uw.op == OP_LOAD) && in_fire;
        do_finish    = (uw.op == OP_FINISH) && out_free;
        do_hold      = (uw.op == OP_HOLD) && out_free;
        do_mul       = (uw.op inside {OP_MUL_EM, OP_MUL_P, OP_MUL_I, OP_MUL_D});
        div_ctl.load = (uw.op == OP_DIVLD_D);
        div_ctl.step = (uw.op == OP_DIV);
    end

    always_comb begin
        case (uw.op)
            OP_MUL_EM: begin
                mul_a = $signed({1'b0, r_m});
                mul_b = MUL_B_W'(r_e);
            end
            OP_MUL_P: begin
                mul_a = MUL_A_W'(r_kp);
                mul_b = MUL_B_W'(r_e);
            end
            OP_MUL_I: begin
                mul_a = MUL_A_W'(r_ki);
                mul_b = $signed({1'b0, r_integ_acc});
            end
            OP_MUL_D: begin
                mul_a = MUL_A_W'(r_kd);
                mul_b = r_de;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign neg_prod = -r_prod;
    assign mag_x125 = {{K125_W{1'b0}}, r_mag} * {{MAG_W{1'b0}}, D_SCALE};

    assign div_num = mag_x125[DIV_NUM_W-1:0];
    assign div_den = {r_m, {TIME_SCALE{1'b0}}};

    pdc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quot  (div_quot),
        .o_last  (div_last)
    );

    assign step_prod = {{RECIP_W{1'b0}}, r_mag[STEP_MAG_W-1:0]}
                     * {{STEP_MAG_W{1'b0}}, STEP_RECIP};
    assign step_q    = (r_mag >= STEP_SAT_MAG) ? ONE_Q16
                                               : step_prod[STEP_SHIFT+DRV_W-1:STEP_SHIFT];
    assign step_ext    = $signed({{(SUM_W-DRV_W){1'b0}}, r_step});
    assign step_signed = r_neg ? -step_ext : step_ext;

    assign in_err   = $signed({i_in_ch.measured[SP_W-1], i_in_ch.measured})
                    - $signed({i_in_ch.setpoint[SP_W-1], i_in_ch.setpoint});
    assign q_ext    = $signed({{(SUM_W-DIV_NUM_W){1'b0}}, div_quot});
    assign q_signed = r_neg ? -q_ext : q_ext;
    assign acc_sum  = $signed({{(SUM_W-DRV_W){1'b0}}, r_integ_acc}) + step_signed;

    // Shifts that truncate toward zero.
    assign p_term = (r_prod + $signed({{(PROD_W-Q88_SHIFT){1'b0}},
                                       {Q88_SHIFT{r_prod[PROD_W-1]}}})) >>> Q88_SHIFT;
    assign i_term = (r_prod + $signed({{(PROD_W-Q16_SHIFT){1'b0}},
                                       {Q16_SHIFT{r_prod[PROD_W-1]}}})) >>> Q16_SHIFT;

    assign drive_new = clamp_unit(r_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= PC_LOAD;
            r_kp         <= '0;
            r_ki         <= '0;
            r_kd         <= '0;
            r_integ_acc  <= '0;
            r_prev_error <= '0;
            r_prev_time  <= '0;
            r_prev_drive <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_PROP:  r_kp <= $signed(i_cfg_data);
                    CFG_INTEG: r_ki <= $signed(i_cfg_data);
                    CFG_DERIV: r_kd <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
            if (uw.op == OP_ACC) begin
                r_integ_acc <= clamp_unit(acc_sum);
            end
            if (do_finish) begin
                r_prev_error <= r_e;
                r_prev_time  <= r_now;
                r_prev_drive <= drive_new;
            end
            if (do_finish || do_hold) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_e   <= in_err;
            r_de  <= MUL_B_W'(in_err) - MUL_B_W'(r_prev_error);
            r_m   <= i_in_ch.now_ms - r_prev_time;
            r_now <= i_in_ch.now_ms;
        end
        if (do_mul) begin
            r_prod <= mul_p;
        end
        if (uw.op == OP_ABS) begin
            r_neg <= r_prod[PROD_W-1];
            r_mag <= r_prod[PROD_W-1] ? neg_prod[MAG_W-1:0] : r_prod[MAG_W-1:0];
        end
        if (uw.op == OP_SCALE_I) begin
            r_step <= step_q;
        end
        case (uw.op)
            OP_ADD_P: r_sum <= SUM_W'(p_term);
            OP_ADD_I: r_sum <= r_sum + SUM_W'(i_term);
            OP_ADD_D: r_sum <= r_sum + q_signed;
            default: ;
        endcase
        if (do_finish) begin
            r_drive <= drive_new;
            r_held  <= 1'b0;
        end else if (do_hold) begin
            r_drive <= r_prev_drive;
            r_held  <= 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ hdl/pdc_divider.sv @@
// Restoring serial divider, one quotient bit per cycle while stepped, unsigned operands.
// Depends on pdc_pkg for widths and the control struct.
`default_nettype none

module pdc_divider import pdc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_div_ctl             i_ctl,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic [DIV_NUM_W-1:0] o_quot,
    output logic                 o_last
);

    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;

    assign trial = {r_rem, r_num[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.load) begin
            r_cnt <= '0;
        end else if (i_ctl.step) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (i_ctl.step) begin
            r_rem <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            r_num <= {r_num[DIV_NUM_W-2:0], fits};
        end
    end

    assign o_quot = r_num;
    assign o_last = (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1));

endmodule

`default_nettype wire

@@ hdl/pdc_checker.sv @@
// Port-level checker for the clamped PID drive core, bound to the top level.
// Depends on pdc_pkg and pid_drive_clamped_core_macros.svh.
`default_nettype none
`include "pid_drive_clamped_core_macros.svh"

module pdc_checker import pdc_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [DRV_W-1:0] i_out_drive,
    input logic             i_out_held
);

    `PDC_CHK_RST(a_reset_empty, !i_rst_n, !i_out_valid, "result word valid after reset")

    `PDC_CHK_NOW(a_drive_range, i_out_valid, i_out_drive <= ONE_Q16, "drive above full scale")

    `PDC_CHK_NEXT(a_one_at_a_time, i_in_valid && i_in_ready, !i_in_ready, "second word taken while busy")

    `PDC_CHK_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_drive) && $stable(i_out_held), "stalled result word changed")

endmodule

bind pid_drive_clamped_core pdc_checker u_pdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_drive (o_out_ch.drive),
    .i_out_held  (o_out_ch.held)
);

`default_nettype wire

@@ verif/pdc_drive_checker.sv @@
// Checker for the clamped PID drive core: follows the gain writes and the input words,
// predicts each drive word and compares it with the output channel in order.
// Depends on pdc_pkg and the channel interfaces in pdc_if.

module pdc_drive_checker import pdc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pdc_in_if                     i_in_ch,
    pdc_out_if                    i_out_ch,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [DRV_W-1:0] drive;
        logic             held;
    } drive_word_t;

    logic signed [GAIN_W-1:0] kp = '0;
    logic signed [GAIN_W-1:0] ki = '0;
    logic signed [GAIN_W-1:0] kd = '0;
    logic [DRV_W-1:0]         integral = '0;
    logic signed [E_W-1:0]    last_error = '0;
    logic [TIME_W-1:0]        last_time = '0;
    logic [DRV_W-1:0]         last_drive = '0;
    drive_word_t              expected_drives[$];
    int                       fails = 0;

    function automatic logic [DRV_W-1:0] limit_to_unit(input longint v);
        if (v < 0) begin
            return '0;
        end
        if (v > longint'(ONE_Q16)) begin
            return ONE_Q16;
        end
        return DRV_W'(v);
    endfunction

    // Returns the drive for one word; a word with nonzero dt also advances the state.
    function automatic drive_word_t next_drive(input logic signed [SP_W-1:0] sp,
                                               input logic signed [SP_W-1:0] pv,
                                               input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] gap_ms;
        longint            e, dt, step, p, i_term, d;
        logic [DRV_W-1:0]  acc, sum;
        drive_word_t       w;
        gap_ms = now - last_time;
        dt = longint'(gap_ms);
        e = longint'(pv) - longint'(sp);
        if (dt == 0) begin
            w.drive = last_drive;
            w.held = 1'b1;
            return w;
        end
        step = (e * dt * 256) / 1000;
        acc = limit_to_unit(longint'(integral) + step);
        p = (longint'(kp) * e) / 256;
        i_term = (longint'(ki) * longint'(acc)) / 65536;
        d = (longint'(kd) * (e - longint'(last_error)) * 1000) / (dt * 256);
        sum = limit_to_unit(p + i_term + d);
        integral = acc;
        last_error = E_W'(e);
        last_time = now;
        last_drive = sum;
        w.drive = sum;
        w.held = 1'b0;
        return w;
    endfunction

    always @(posedge i_clk) begin : monitor
        drive_word_t got;
        drive_word_t want;
        if (!i_rst_n) begin
            kp = '0;
            ki = '0;
            kd = '0;
            integral = '0;
            last_error = '0;
            last_time = '0;
            last_drive = '0;
            expected_drives.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_PROP:  kp = i_cfg_data;
                    CFG_INTEG: ki = i_cfg_data;
                    CFG_DERIV: kd = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                expected_drives.push_back(next_drive(i_in_ch.setpoint, i_in_ch.measured,
                                                     i_in_ch.now_ms));
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                got.drive = i_out_ch.drive;
                got.held = i_out_ch.held;
                if (expected_drives.size() == 0) begin
                    $error("unexpected drive word: drive %0d held %0d", got.drive, got.held);
                    fails++;
                end else begin
                    want = expected_drives.pop_front();
                    if (got.drive !== want.drive) begin
                        $error("drive: expected %0d, actual %0d", want.drive, got.drive);
                        fails++;
                    end
                    if (got.held !== want.held) begin
                        $error("held: expected %0d, actual %0d", want.held, got.held);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= expected_drives.size();
    end

endmodule

@@ verif/tb.sv @@
// Top of the clamped PID drive core testbench: clock, reset, gain writes, input words
// and output back-pressure; the checker beside the core predicts and compares.
// Depends on pdc_pkg, pdc_if, pid_drive_clamped_core and pdc_drive_checker.

module tb;
    import pdc_pkg::*;

    localparam int RUN_LIMIT       = 1_000_000;
    localparam int LONG_HOLD       = 600;
    localparam int DRAIN_WAIT      = 150;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 205;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int                    fail_count;
    int                    pending;
    int                    cycles = 0;
    bit                    no_idle = 1'b0;
    bit                    hold_request = 1'b0;
    logic [TIME_W-1:0]     t_now = '0;

    pdc_in_if  in_ch();
    pdc_out_if out_ch();

    pid_drive_clamped_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    pdc_drive_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        in_ch.valid = 1'b0;
        in_ch.setpoint = '0;
        in_ch.measured = '0;
        in_ch.now_ms = '0;
        out_ch.ready = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("pid_drive_clamped_core: mismatch");
            $finish;
        end
    end

    // Zero half the time, otherwise mostly short gaps and a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input logic signed [SP_W-1:0] sp,
                             input logic signed [SP_W-1:0] pv,
                             input logic [TIME_W-1:0] t);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.setpoint <= sp;
        in_ch.measured <= pv;
        in_ch.now_ms <= t;
        do @(posedge i_clk); while (!in_ch.ready);
        t_now = t;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_gains(input logic [CFG_DATA_W-1:0] kp,
                             input logic [CFG_DATA_W-1:0] ki,
                             input logic [CFG_DATA_W-1:0] kd);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_PROP;
        i_cfg_data <= kp;
        @(posedge i_clk);
        i_cfg_idx <= CFG_INTEG;
        i_cfg_data <= ki;
        @(posedge i_clk);
        i_cfg_idx <= CFG_DERIV;
        i_cfg_data <= kd;
        @(posedge i_clk);
        // A write to the unused index must leave all gains alone.
        i_cfg_idx <= CFG_SPARE;
        i_cfg_data <= $urandom;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] moderate_gain(input int span);
        return CFG_DATA_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    always begin : receiver
        int stall;
        if (hold_request) begin
            hold_request = 1'b0;
            out_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge i_clk);
        end else begin
            stall = no_idle ? 0 : pick_gap();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
        out_ch.ready <= 1'b1;
        do @(posedge i_clk); while (!out_ch.valid);
    end

    initial begin : stimulus
        int                      r;
        int                      v;
        logic signed [SP_W-1:0]  sp;
        logic signed [SP_W-1:0]  pv;
        logic [TIME_W-1:0]       t;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // First word after reset sees zero elapsed time, the second a dt equal to its stamp.
        send_word(16'sd0, 16'sd0, 32'd0);
        send_word(16'sd0, 16'sd50, 32'd5);
        wait_drained();
        set_gains(32'd65536, 32'd65536, 32'd4096);

        send_word(-16'sd32768, 16'sd32767, 32'd10);
        send_word(-16'sd32768, 16'sd32767, 32'd10);
        send_word(16'sd32767, -16'sd32768, 32'd11);
        send_word(16'sd0, 16'sd100, 32'd20);
        send_word(16'sd0, 16'sd100, 32'hFFFF_FFFF);
        send_word(16'sd10, 16'sd0, 32'd3);
        send_word(16'sd0, 16'sd20, 32'd2);
        send_word(-16'sd32768, -16'sd32768, 32'd1000);
        send_word(16'sd32767, 16'sd32767, 32'd1001);
        send_word(16'sd0, -16'sd1, 32'h8000_0000);
        send_word(16'sd1, 16'sd0, 32'h8000_0001);
        send_word(16'sd1, 16'sd0, 32'h8000_0001);
        send_word(-16'sd256, 16'sd256, 32'h8000_0010);
        send_word(16'sd0, 16'sd200, 32'h8000_0011);
        send_word(16'sd0, 16'sd0, 32'h8000_0030);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: set_gains(32'd65536, 32'd32768, 32'd256);
                1: set_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                2: set_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
                3: set_gains($urandom, $urandom, $urandom);
                4: set_gains(moderate_gain(262144), moderate_gain(262144),
                             moderate_gain(4096));
                default: set_gains(32'd0, -32'sd65536, moderate_gain(65536));
            endcase
            no_idle = (ph == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 0 && n == 100) begin
                    hold_request = 1'b1;
                end
                t = t_now;
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    t = t_now;
                end else if (r < 78) begin
                    t = t_now + $urandom_range(1, 50);
                end else if (r < 86) begin
                    t = t_now + $urandom_range(51, 5000);
                end else if (r < 90) begin
                    t = t_now - $urandom_range(1, 100);
                end else if (r < 95) begin
                    t = $urandom;
                end else begin
                    t = t_now + $urandom_range(100000, 10000000);
                end
                r = $urandom_range(0, 99);
                if (r < 20) begin
                    sp = SP_W'($urandom);
                    pv = SP_W'($urandom);
                end else if (r < 25) begin
                    sp = r[0] ? -16'sd32768 : 16'sd32767;
                    pv = r[1] ? -16'sd32768 : 16'sd32767;
                end else begin
                    sp = SP_W'($urandom);
                    v = int'(sp) + int'($urandom_range(0, 1200)) - 600;
                    if (v > 32767) begin
                        v = 32767;
                    end else if (v < -32768) begin
                        v = -32768;
                    end
                    pv = SP_W'(v);
                end
                send_word(sp, pv, t);
            end
        end

        wait_drained();
        no_idle = 1'b0;
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("pid_drive_clamped_core: match");
        end else begin
            $display("pid_drive_clamped_core: mismatch");
        end
        $finish;
    end

endmodule
